@@ design/scntd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scntd_pkg;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_READING = 2'd0,
        KIND_CRC_GOOD = 2'd1,
        KIND_CRC_BAD = 2'd2
    } scntd_kind_t;

    // header field constants
    localparam logic [7:0] DEV_ID_HI = 8'hFF;
    localparam logic [7:0] DEV_ID_LO = 8'h07;
    localparam logic [7:0] VER_A_HI = 8'h00;
    localparam logic [7:0] VER_B_HI = 8'h02;
    localparam logic [7:0] VER_LO = 8'h01;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // word count limits: payload = 2 * words - 17, readings = words - 12
    localparam int unsigned LEN_BIAS = 17;
    localparam int unsigned MIN_WORDS = 12;
    localparam int unsigned SYNC_ZEROS = 6;
    localparam int unsigned CRC_START_ZERO = 4;
    localparam int unsigned FIRST_READING_POS = 6;

    // one result beat
    typedef struct packed {
        scntd_kind_t kind;
        logic [10:0] reading_index;
        logic [15:0] reading_raw;
        logic [7:0] status_flags;
        logic [31:0] time_stamp;
        logic [15:0] telegram_number;
        logic [10:0] reading_count;
        logic [15:0] received_check;
        logic [15:0] computed_check;
    } scntd_result_t;

    // crc-16, msb first, one byte folded in over eight bit steps
    function automatic logic [15:0] scntd_crc_feed(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/scntd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scntd_core #(
    parameter int unsigned MAX_PAYLOAD = 4096
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic in_fire,
    input wire logic [7:0] rx_byte,
    output logic res_valid,
    output scntd_pkg::scntd_result_t res
);
    import scntd_pkg::*;

    localparam int unsigned PLW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned NW = (PLW > 11) ? PLW : 11;
    localparam int unsigned WMAX = (MAX_PAYLOAD + LEN_BIAS) / 2;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DEV0,
        PH_DEV1,
        PH_VER0,
        PH_VER1,
        PH_STATUS,
        PH_TIME,
        PH_TELE,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [PLW-1:0] pos_reg, pos_next;
    logic [PLW-1:0] len_reg, len_next;
    logic [NW-1:0] nread_reg, nread_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] status_reg, status_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] tele_reg, tele_next;
    logic [7:0] trail_reg, trail_next;

    logic [15:0] crc_fed;
    logic [PLW-1:0] pos_inc;
    logic [16:0] word_cnt;
    logic [16:0] len_calc;
    logic [16:0] nread_calc;
    logic [NW-1:0] k_idx;
    logic [15:0] rx_check;

    assign crc_fed = scntd_crc_feed(crc_reg, rx_byte);
    assign pos_inc = pos_reg + PLW'(1);
    assign word_cnt = {1'b0, held_reg, rx_byte};
    assign len_calc = {word_cnt[15:0], 1'b0} - 17'(LEN_BIAS);
    assign nread_calc = word_cnt - 17'(MIN_WORDS);
    assign k_idx = NW'((pos_reg - PLW'(FIRST_READING_POS)) >> 1);
    assign rx_check = {rx_byte, trail_reg};

    // parser next state and result beat
    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        nread_next = nread_reg;
        held_next = held_reg;
        status_next = status_reg;
        time_next = time_reg;
        tele_next = tele_reg;
        trail_next = trail_reg;
        if (phase_reg == PH_HUNT || phase_reg == PH_CRC_LO || phase_reg == PH_CRC_HI) begin
            crc_next = crc_reg;
        end else begin
            crc_next = crc_fed;
        end

        res_valid = 1'b0;
        res.kind = KIND_READING;
        res.reading_index = 11'd0;
        res.reading_raw = 16'd0;
        res.status_flags = status_reg;
        res.time_stamp = time_reg;
        res.telegram_number = tele_reg;
        res.reading_count = nread_reg[10:0];
        res.received_check = 16'd0;
        res.computed_check = 16'd0;

        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte != 8'd0) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc;
                    if (pos_inc == PLW'(CRC_START_ZERO)) begin
                        crc_next = CRC_INIT;
                    end else if (pos_inc > PLW'(CRC_START_ZERO)) begin
                        crc_next = crc_fed;
                    end
                    if (pos_inc >= PLW'(SYNC_ZEROS)) begin
                        phase_next = PH_LEN_HI;
                        pos_next = '0;
                    end
                end
            end
            PH_LEN_HI: begin
                held_next = rx_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (word_cnt < 17'(MIN_WORDS) || word_cnt > 17'(WMAX)) begin
                    phase_next = PH_HUNT;
                    pos_next = '0;
                end else begin
                    len_next = len_calc[PLW-1:0];
                    nread_next = nread_calc[NW-1:0];
                    phase_next = PH_DEV0;
                end
            end
            PH_DEV0: begin
                held_next = rx_byte;
                phase_next = PH_DEV1;
            end
            PH_DEV1: begin
                if (held_reg == DEV_ID_HI && rx_byte == DEV_ID_LO) begin
                    phase_next = PH_VER0;
                end else begin
                    phase_next = PH_HUNT;
                    pos_next = '0;
                end
            end
            PH_VER0: begin
                held_next = rx_byte;
                phase_next = PH_VER1;
            end
            PH_VER1: begin
                if ((held_reg == VER_A_HI || held_reg == VER_B_HI) && rx_byte == VER_LO) begin
                    phase_next = PH_STATUS;
                end else begin
                    phase_next = PH_HUNT;
                    pos_next = '0;
                end
            end
            PH_STATUS: begin
                status_next = rx_byte;
                pos_next = '0;
                phase_next = PH_TIME;
            end
            PH_TIME: begin
                // first byte ends up in bits 7:0 after four shifts
                time_next = {rx_byte, time_reg[31:8]};
                pos_next = pos_inc;
                if (pos_reg == PLW'(3)) begin
                    pos_next = '0;
                    phase_next = PH_TELE;
                end
            end
            PH_TELE: begin
                tele_next = {rx_byte, tele_reg[15:8]};
                pos_next = pos_inc;
                if (pos_reg == PLW'(1)) begin
                    pos_next = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                // a reading completes on every even offset from six on while its index is below the reading count
                if (pos_reg >= PLW'(FIRST_READING_POS) && !pos_reg[0]
                        && k_idx < nread_reg) begin
                    res_valid = in_fire;
                    res.kind = KIND_READING;
                    res.reading_index = k_idx[10:0];
                    res.reading_raw = {rx_byte, held_reg};
                end
                held_next = rx_byte;
                pos_next = pos_inc;
                if (pos_inc >= len_reg) begin
                    pos_next = '0;
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                trail_next = rx_byte;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                res_valid = in_fire;
                res.kind = (rx_check == crc_reg) ? KIND_CRC_GOOD : KIND_CRC_BAD;
                res.received_check = rx_check;
                res.computed_check = crc_reg;
                phase_next = PH_HUNT;
                pos_next = '0;
            end
            default: begin
                phase_next = PH_HUNT;
                pos_next = '0;
            end
        endcase
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // header and frame fields
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            len_reg <= len_next;
            nread_reg <= nread_next;
            held_reg <= held_next;
            status_reg <= status_next;
            time_reg <= time_next;
            tele_reg <= tele_next;
            trail_reg <= trail_next;
        end
    end

    // checks
    a_end_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && phase_reg == PH_CRC_HI |-> res_valid)
        else $error("frame end without result beat");

    a_end_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && phase_reg == PH_CRC_HI |=> phase_reg == PH_HUNT && pos_reg == '0)
        else $error("no return to hunt after frame end");

    a_beat_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> phase_reg == PH_PAYLOAD || phase_reg == PH_CRC_HI)
        else $error("result beat outside payload or trailer");

    a_pos_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pos_reg < len_reg)
        else $error("payload offset past length");

endmodule

`default_nettype wire

@@ design/scntd_outreg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scntd_outreg (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic load,
    input wire scntd_pkg::scntd_result_t load_data,
    output logic in_ready,
    output logic out_valid,
    input wire logic out_ready,
    output scntd_pkg::scntd_result_t out_data
);
    import scntd_pkg::*;

    logic valid_reg;
    scntd_result_t data_reg;

    // a new byte may enter when the held beat is empty or leaves now
    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> in_ready)
        else $error("result loaded over a waiting beat");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg && data_reg == $past(load_data))
        else $error("loaded beat not presented");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled beat changed");

endmodule

`default_nettype wire

@@ design/scanner_telegram_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Telegram deframer for a scanner serial byte stream. One byte is taken per beat on the
// s_ channel; the block hunts for six zero bytes, checks the header (word count, device
// id FF 07, version 00 01 or 02 01), captures status, timestamp and telegram number, then
// emits one m_ beat per 16-bit little-endian reading and a final beat that reports whether
// the CRC-16 (poly 1021, init FFFF, from the fifth zero byte to the end of payload) matches
// the trailer. A bad header field or a length outside 7..MAX_PAYLOAD drops back to the hunt
// silently. The parser state and the byte-wide CRC update sit between the input
// handshake and a single output register, so a byte is accepted in every cycle while the
// output register is empty or being drained, and results appear in the cycle after the
// byte that completes them.
module scanner_telegram_deframer #(
    parameter int unsigned MAX_PAYLOAD = 4096
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic [7:0] s_rx_byte,
    output logic m_valid,
    input wire logic m_ready,
    output logic [1:0] m_kind,
    output logic [10:0] m_reading_index,
    output logic [15:0] m_reading_raw,
    output logic [7:0] m_status_flags,
    output logic [31:0] m_time_stamp,
    output logic [15:0] m_telegram_number,
    output logic [10:0] m_reading_count,
    output logic [15:0] m_received_check,
    output logic [15:0] m_computed_check
);
    import scntd_pkg::*;

    logic in_fire;
    logic res_valid;
    scntd_result_t res;
    scntd_result_t out_data;

    assign in_fire = s_valid && s_ready;

    // byte parser
    scntd_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_fire(in_fire),
        .rx_byte(s_rx_byte),
        .res_valid(res_valid),
        .res(res)
    );

    // result register
    scntd_outreg u_outreg (
        .aclk(aclk),
        .aresetn(aresetn),
        .load(res_valid),
        .load_data(res),
        .in_ready(s_ready),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data(out_data)
    );

    assign m_kind = out_data.kind;
    assign m_reading_index = out_data.reading_index;
    assign m_reading_raw = out_data.reading_raw;
    assign m_status_flags = out_data.status_flags;
    assign m_time_stamp = out_data.time_stamp;
    assign m_telegram_number = out_data.telegram_number;
    assign m_reading_count = out_data.reading_count;
    assign m_received_check = out_data.received_check;
    assign m_computed_check = out_data.computed_check;

endmodule

`default_nettype wire
